/* src/idaps_pkg.sv */
// Shared types, codes and lookup functions of the I2C DAC/ADC poll sequencer.
`default_nettype none

package idaps_pkg;

    localparam int DEVICE_COUNT_DEF = 6;
    localparam int QUEUE_DEPTH      = 2;
    localparam int Q_AW             = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int Q_CW             = $clog2(QUEUE_DEPTH + 1);

    // item classes decided by the front end
    localparam logic [1:0] KIND_EVENT    = 2'd0;
    localparam logic [1:0] KIND_POLL     = 2'd1;
    localparam logic [1:0] KIND_SETPOINT = 2'd2;
    localparam logic [1:0] KIND_IGNORE   = 2'd3;

    // input mode codes
    localparam logic [1:0] MODE_EVENT    = 2'd0;
    localparam logic [1:0] MODE_POLL     = 2'd1;
    localparam logic [1:0] MODE_SETPOINT = 2'd2;

    // bus commands
    localparam logic [2:0] CMD_START   = 3'd0;
    localparam logic [2:0] CMD_STOP    = 3'd1;
    localparam logic [2:0] CMD_SEND    = 3'd2;
    localparam logic [2:0] CMD_RECV    = 3'd3;
    localparam logic [2:0] CMD_DISABLE = 3'd4;
    localparam logic [2:0] CMD_NONE    = 3'd5;

    // bus controller status codes
    localparam logic [7:0] ST_IDLE      = 8'h00;
    localparam logic [7:0] ST_START     = 8'h08;
    localparam logic [7:0] ST_REP_START = 8'h10;
    localparam logic [7:0] ST_MTX_ADR   = 8'h18;
    localparam logic [7:0] ST_MTX_DATA  = 8'h28;
    localparam logic [7:0] ST_MRX_ADR   = 8'h40;
    localparam logic [7:0] ST_MRX_DATA  = 8'h50;

    localparam logic [7:0] ERR_STEP     = 8'hFF;
    localparam logic [7:0] ADC_CFG_HI   = 8'h84;
    localparam logic [7:0] ADC_CFG_LO   = 8'hA0;
    localparam logic [7:0] ADC_PTR_CFG  = 8'h01;
    localparam logic [7:0] ADC_PTR_CONV = 8'h00;

    // configuration register indexes
    localparam logic [2:0] CFG_DAC_GAIN     = 3'd0;
    localparam logic [2:0] CFG_DAC_OFFSET   = 3'd1;
    localparam logic [2:0] CFG_ADC_GAIN     = 3'd2;
    localparam logic [2:0] CFG_ADC_OFFSET   = 3'd3;
    localparam logic [2:0] CFG_SETUP_PASSES = 3'd4;

    localparam logic [7:0] SETUP_PASSES_RESET = 8'd100;
    localparam logic [11:0] DAC_CODE_MAX      = 12'd4095;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  status;
        logic [7:0]  rx;
        logic [1:0]  sp_index;
        logic [15:0] sp_value;
    } t_item;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [7:0]  tx;
        logic        adc_valid;
        logic [1:0]  adc_channel;
        logic [15:0] adc_value;
    } t_result;

    function automatic logic [7:0] dac_addr(input logic [1:0] ch);
        logic [7:0] a;
        unique case (ch)
            2'd0:    a = 8'h98;
            2'd1:    a = 8'h9A;
            2'd2:    a = 8'hC0;
            default: a = 8'hC2;
        endcase
        return a;
    endfunction

    function automatic logic [7:0] adc_addr(input logic ch);
        return ch ? 8'h92 : 8'h90;
    endfunction

    function automatic logic [15:0] lane16(input logic [63:0] w, input logic [1:0] ch);
        logic [15:0] v;
        unique case (ch)
            2'd0:    v = w[15:0];
            2'd1:    v = w[31:16];
            2'd2:    v = w[47:32];
            default: v = w[63:48];
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

/* src/idaps_front.sv */
// Front end: accepts input items and classifies them by mode.
`default_nettype none

module idaps_front
    import idaps_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [1:0]  i_mode,
    input  wire logic [7:0]  i_bus_status,
    input  wire logic [7:0]  i_rx_byte,
    input  wire logic [1:0]  i_setpoint_index,
    input  wire logic [15:0] i_setpoint_value,
    input  wire logic        i_q_full,
    output logic             o_q_push,
    output t_item            o_q_item
);

    logic [1:0] kind;
    logic       r_busy_seen;

    always_comb begin
        unique case (i_mode)
            MODE_EVENT:    kind = KIND_EVENT;
            MODE_POLL:     kind = KIND_POLL;
            MODE_SETPOINT: kind = KIND_SETPOINT;
            default:       kind = KIND_IGNORE;
        endcase
    end

    // hold off the source while the queue is full and after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy_seen <= 1'b0;
        end else begin
            r_busy_seen <= 1'b1;
        end
    end

    assign o_in_stall = i_q_full || !r_busy_seen;
    assign o_q_push   = i_in_valid && !o_in_stall;

    always_comb begin
        o_q_item          = '0;
        o_q_item.kind     = kind;
        o_q_item.status   = i_bus_status;
        o_q_item.rx       = i_rx_byte;
        o_q_item.sp_index = i_setpoint_index;
        o_q_item.sp_value = i_setpoint_value;
    end

endmodule

`default_nettype wire

/* src/idaps_queue.sv */
// Short FIFO of classified items between the front end and the back end.
`default_nettype none

module idaps_queue
    import idaps_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_push,
    input  wire t_item i_item,
    output logic       o_full,
    output logic       o_valid,
    output t_item      o_item,
    input  wire logic  i_pop
);

    localparam logic [Q_AW-1:0] LAST_PTR = Q_AW'(QUEUE_DEPTH - 1);
    localparam logic [Q_CW-1:0] FULL_CNT = Q_CW'(QUEUE_DEPTH);

    t_item           r_mem [QUEUE_DEPTH];
    logic [Q_AW-1:0] r_wr_ptr;
    logic [Q_AW-1:0] r_rd_ptr;
    logic [Q_CW-1:0] r_count;
    logic [Q_AW-1:0] n_wr_ptr;
    logic [Q_AW-1:0] n_rd_ptr;
    logic [Q_CW-1:0] n_count;
    logic            do_push;
    logic            do_pop;

    assign o_full  = (r_count == FULL_CNT);
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + Q_AW'(1);
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + Q_AW'(1);
        end
        if (do_push && !do_pop) begin
            n_count = r_count + Q_CW'(1);
        end else if (do_pop && !do_push) begin
            n_count = r_count - Q_CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

endmodule

`default_nettype wire

/* src/idaps_back.sv */
// Back end: runs the bus transactions, scaling and poll rotation, one item a cycle while the output is not stalled.
`default_nettype none

module idaps_back
    import idaps_pkg::*;
#(
    parameter int P_DEVICE_COUNT = DEVICE_COUNT_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [63:0] i_cfg_data,
    input  wire logic        i_q_valid,
    input  wire t_item       i_q_item,
    output logic             o_q_pop,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output t_result          o_result
);

    localparam logic [3:0] DEV_WRAP = 4'(P_DEVICE_COUNT);

    // configuration
    logic [63:0] r_dac_gain;
    logic [63:0] r_dac_offset;
    logic [63:0] r_adc_gain;
    logic [63:0] r_adc_offset;

    // sequencer state
    logic [7:0]  r_step;
    logic [2:0]  r_dev;
    logic [7:0]  r_countdown;
    logic [11:0] r_codes [4];
    logic [15:0] r_raw   [2];
    logic [15:0] r_sp    [4];
    logic [7:0]  n_step;
    logic [2:0]  n_dev;
    logic [7:0]  n_countdown;
    logic [11:0] n_codes [4];
    logic [15:0] n_raw   [2];
    logic [15:0] n_sp    [4];

    logic        r_out_valid;
    t_result     r_out;
    t_result     res;

    // decode of the current item against the current device
    logic [7:0]  st;
    logic        start_ok;
    logic        adr_ok;
    logic        tx_ok;
    logic        rx_ok;
    logic        is_adc;
    logic        adc_c;
    logic [1:0]  dac_ch;
    logic [7:0]  step_inc;
    logic        err;
    logic [7:0]  ev_step;
    logic [11:0] cur_code;

    // ADC scaling
    logic [15:0]        adc_gain;
    logic [15:0]        adc_off;
    logic signed [16:0] adc_diff;
    logic signed [32:0] adc_prod;
    logic signed [18:0] adc_sh;
    logic [15:0]        adc_sat;

    // DAC scaling for the next device
    logic [3:0]         nxt4;
    logic [2:0]         nxt;
    logic [15:0]        dac_sp;
    logic [15:0]        dac_gain;
    logic [15:0]        dac_off;
    logic signed [31:0] dac_prod;
    logic signed [15:0] dac_q;
    logic signed [16:0] dac_sum;
    logic [11:0]        dac_clamp;

    assign o_q_pop     = i_q_valid && (!r_out_valid || !i_out_stall);
    assign o_out_valid = r_out_valid;
    assign o_result    = r_out;

    assign st       = i_q_item.status;
    assign start_ok = (st == ST_START) || (st == ST_REP_START);
    assign adr_ok   = (st == ST_MTX_ADR) || (st == ST_MRX_ADR);
    assign tx_ok    = (st == ST_MTX_DATA);
    assign rx_ok    = (st == ST_MRX_DATA);
    assign is_adc   = (r_dev == 3'd4) || (r_dev == 3'd5);
    assign adc_c    = r_dev[0];
    assign dac_ch   = r_dev[2] ? 2'd0 : r_dev[1:0];
    assign step_inc = r_step + 8'd1;
    assign cur_code = r_codes[dac_ch];

    // transaction step error check, per transaction type
    always_comb begin
        if (!is_adc) begin
            err = ((step_inc == 8'd1) && !start_ok) || ((step_inc == 8'd2) && !adr_ok) ||
                  (((step_inc == 8'd3) || (step_inc == 8'd4)) && !tx_ok);
        end else if (r_countdown != 8'd0) begin
            err = (((step_inc == 8'd1) || (step_inc == 8'd6)) && !start_ok) ||
                  (((step_inc == 8'd2) || (step_inc == 8'd7)) && !adr_ok) ||
                  (((step_inc == 8'd3) || (step_inc == 8'd4) || (step_inc == 8'd5) ||
                    (step_inc == 8'd8)) && !tx_ok);
        end else begin
            err = ((step_inc == 8'd1) && !start_ok) || ((step_inc == 8'd2) && !adr_ok) ||
                  (((step_inc == 8'd3) || (step_inc == 8'd4)) && !rx_ok);
        end
    end
    assign ev_step = err ? ERR_STEP : step_inc;

    // ADC: (raw - offset) * gain, floor shift by 14, saturate
    assign adc_gain = lane16(r_adc_gain, {1'b0, adc_c});
    assign adc_off  = lane16(r_adc_offset, {1'b0, adc_c});
    assign adc_diff = $signed({r_raw[adc_c][15], r_raw[adc_c]}) - $signed({adc_off[15], adc_off});
    assign adc_prod = adc_diff * $signed(adc_gain);
    assign adc_sh   = adc_prod[32:14];

    always_comb begin
        if (adc_sh > 19'sd32767) begin
            adc_sat = 16'h7FFF;
        end else if (adc_sh < -19'sd32768) begin
            adc_sat = 16'h8000;
        end else begin
            adc_sat = adc_sh[15:0];
        end
    end

    // DAC: setpoint * gain, floor shift by 16, add offset, clamp to code range
    assign nxt4     = {1'b0, r_dev} + 4'd1;
    assign nxt      = (nxt4 >= DEV_WRAP) ? 3'd0 : nxt4[2:0];
    assign dac_sp   = r_sp[nxt[1:0]];
    assign dac_gain = lane16(r_dac_gain, nxt[1:0]);
    assign dac_off  = lane16(r_dac_offset, nxt[1:0]);
    assign dac_prod = $signed(dac_sp) * $signed(dac_gain);
    assign dac_q    = dac_prod[31:16];
    assign dac_sum  = $signed({dac_q[15], dac_q}) + $signed({dac_off[15], dac_off});

    always_comb begin
        if (dac_sum < 17'sd0) begin
            dac_clamp = 12'd0;
        end else if (dac_sum > 17'sd4095) begin
            dac_clamp = DAC_CODE_MAX;
        end else begin
            dac_clamp = dac_sum[11:0];
        end
    end

    always_comb begin
        n_step      = r_step;
        n_dev       = r_dev;
        n_countdown = r_countdown;
        n_codes     = r_codes;
        n_raw       = r_raw;
        n_sp        = r_sp;
        res         = '0;
        res.cmd     = CMD_NONE;

        unique case (i_q_item.kind)
            KIND_EVENT: begin
                n_step = ev_step;
                if (!is_adc) begin
                    unique case (ev_step)
                        8'd1: begin
                            res.cmd = CMD_SEND;
                            res.tx  = dac_addr(dac_ch);
                        end
                        8'd2: begin
                            res.cmd = CMD_SEND;
                            res.tx  = {4'd0, cur_code[11:8]};
                        end
                        8'd3: begin
                            res.cmd = CMD_SEND;
                            res.tx  = cur_code[7:0];
                        end
                        default: res.cmd = CMD_STOP;
                    endcase
                end else if (r_countdown != 8'd0) begin
                    unique case (ev_step) inside
                        8'd1, 8'd6: begin
                            res.cmd = CMD_SEND;
                            res.tx  = adc_addr(adc_c);
                        end
                        8'd2: begin
                            res.cmd = CMD_SEND;
                            res.tx  = ADC_PTR_CFG;
                        end
                        8'd3: begin
                            res.cmd = CMD_SEND;
                            res.tx  = ADC_CFG_HI;
                        end
                        8'd4: begin
                            res.cmd = CMD_SEND;
                            res.tx  = ADC_CFG_LO;
                        end
                        8'd5:    res.cmd = CMD_START;
                        8'd7: begin
                            res.cmd = CMD_SEND;
                            res.tx  = ADC_PTR_CONV;
                        end
                        default: res.cmd = CMD_STOP;
                    endcase
                end else begin
                    // raw capture follows the step count, not the error outcome
                    if (step_inc == 8'd3) begin
                        n_raw[adc_c] = {i_q_item.rx, 8'd0};
                    end else if (step_inc == 8'd4) begin
                        n_raw[adc_c] = {r_raw[adc_c][15:8], r_raw[adc_c][7:0] | i_q_item.rx};
                    end else if (step_inc != 8'd1 && step_inc != 8'd2) begin
                        n_raw[adc_c] = 16'd0;
                    end
                    unique case (ev_step) inside
                        8'd1: begin
                            res.cmd = CMD_SEND;
                            res.tx  = adc_addr(adc_c) | 8'h01;
                        end
                        8'd2, 8'd3: res.cmd = CMD_RECV;
                        default:    res.cmd = CMD_STOP;
                    endcase
                end
            end
            KIND_POLL: begin
                if (r_countdown != 8'd0) begin
                    n_countdown = r_countdown - 8'd1;
                end else if (is_adc) begin
                    res.adc_valid   = 1'b1;
                    res.adc_channel = {1'b0, adc_c};
                    res.adc_value   = adc_sat;
                end
                n_dev = nxt;
                if (!nxt[2]) begin
                    n_codes[nxt[1:0]] = dac_clamp;
                end
                if (st == ST_IDLE) begin
                    res.cmd = CMD_STOP;
                end else if (r_step == 8'd0) begin
                    // skip one poll after an error
                    n_step  = 8'd1;
                    res.cmd = CMD_DISABLE;
                end else begin
                    n_step  = 8'd0;
                    res.cmd = CMD_START;
                end
            end
            KIND_SETPOINT: begin
                n_sp[i_q_item.sp_index] = i_q_item.sp_value;
            end
            default: begin
                res.cmd = CMD_NONE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dac_gain     <= '0;
            r_dac_offset   <= '0;
            r_adc_gain     <= '0;
            r_adc_offset   <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_DAC_GAIN:     r_dac_gain     <= i_cfg_data;
                CFG_DAC_OFFSET:   r_dac_offset   <= i_cfg_data;
                CFG_ADC_GAIN:     r_adc_gain     <= i_cfg_data;
                CFG_ADC_OFFSET:   r_adc_offset   <= i_cfg_data;
                // the pass count only takes effect at reset; drop the write
                CFG_SETUP_PASSES: ;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step      <= '0;
            r_dev       <= '0;
            // the countdown loads from the register's reset value
            r_countdown <= SETUP_PASSES_RESET;
            r_codes     <= '{default: '0};
            r_raw       <= '{default: '0};
            r_sp        <= '{default: '0};
        end else if (o_q_pop) begin
            r_step      <= n_step;
            r_dev       <= n_dev;
            r_countdown <= n_countdown;
            r_codes     <= n_codes;
            r_raw       <= n_raw;
            r_sp        <= n_sp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_q_pop) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_out <= res;
        end
    end

endmodule

`default_nettype wire

/* src/i2c_dac_adc_poll_sequencer.sv */
// Top level of the I2C DAC/ADC poll sequencer: front end, item queue, back end.
// Path: an accepted item is written into the queue, and its result is registered in the output register when popped.
// Throughput: one item per cycle while the output is not stalled.
// A two-entry queue lets input accept while a finished result waits on the output.
// Reset: synchronous active low; input is held off during reset and until the busy-seen flag sets, no clearing pass.
`default_nettype none

module i2c_dac_adc_poll_sequencer
    import idaps_pkg::*;
#(
    parameter int P_DEVICE_COUNT = DEVICE_COUNT_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [63:0] i_cfg_data,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [1:0]  i_mode,
    input  wire logic [7:0]  i_bus_status,
    input  wire logic [7:0]  i_rx_byte,
    input  wire logic [1:0]  i_setpoint_index,
    input  wire logic signed [15:0] i_setpoint_value,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [2:0]       o_bus_command,
    output logic [7:0]       o_tx_byte,
    output logic             o_adc_valid,
    output logic [1:0]       o_adc_channel,
    output logic signed [15:0] o_adc_value
);

    logic    q_full;
    logic    q_push;
    t_item   q_in_item;
    logic    q_valid;
    t_item   q_out_item;
    logic    q_pop;
    t_result result;

    idaps_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_mode           (i_mode),
        .i_bus_status     (i_bus_status),
        .i_rx_byte        (i_rx_byte),
        .i_setpoint_index (i_setpoint_index),
        .i_setpoint_value (i_setpoint_value),
        .i_q_full         (q_full),
        .o_q_push         (q_push),
        .o_q_item         (q_in_item)
    );

    idaps_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_item  (q_in_item),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_item  (q_out_item),
        .i_pop   (q_pop)
    );

    idaps_back #(
        .P_DEVICE_COUNT (P_DEVICE_COUNT)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_q_valid   (q_valid),
        .i_q_item    (q_out_item),
        .o_q_pop     (q_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_result    (result)
    );

    assign o_bus_command = result.cmd;
    assign o_tx_byte     = result.tx;
    assign o_adc_valid   = result.adc_valid;
    assign o_adc_channel = result.adc_channel;
    assign o_adc_value   = result.adc_value;

endmodule

`default_nettype wire
